// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes for the sorted priority queue
// Request and response payloads, operation codes, status codes and the
// per-cycle command that the queue control hands to every cell.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Operation codes carried in the kind field
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Status codes returned with every response
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Field widths of the external payloads
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned PrioWidth  = 16;
  localparam int unsigned OccWidth   = 5;

  typedef struct packed {
    logic                         kind;
    logic [ValueWidth-1:0]        item_value;
    logic signed [PrioWidth-1:0]  priority_req;
  } spq_req_t;

  typedef struct packed {
    logic [ValueWidth-1:0] popped_value;
    logic [1:0]            status;
    logic                  now_empty;
    logic [OccWidth-1:0]   occupancy;
  } spq_rsp_t;

  // Command broadcast to the whole chain at once
  typedef struct packed {
    logic push;
    logic pop;
  } spq_cmd_t;

endpackage

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry and its occupied flag. On a push it holds, takes the new
// entry or takes its left neighbour's entry; on a pop it takes its right
// neighbour's entry.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int unsigned PLW = 32,
  parameter int unsigned PRW = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::spq_cmd_t   cmd_i,
  input  logic [PLW-1:0]      new_payload_i,
  input  logic [PRW-1:0]      new_prio_i,
  // left neighbour (nearer the head)
  input  logic                left_gt_i,
  input  logic                left_occ_i,
  input  logic [PLW-1:0]      left_payload_i,
  input  logic [PRW-1:0]      left_prio_i,
  // right neighbour (nearer the tail)
  input  logic                right_occ_i,
  input  logic [PLW-1:0]      right_payload_i,
  input  logic [PRW-1:0]      right_prio_i,
  // own contents
  output logic                gt_o,
  output logic                occ_o,
  output logic [PLW-1:0]      payload_o,
  output logic [PRW-1:0]      prio_o
);

  logic           occ_q, occ_d;
  logic [PLW-1:0] payload_q, payload_d;
  logic [PRW-1:0] prio_q, prio_d;

  // stored entry outranks the incoming one: it stays where it is
  assign gt_o = occ_q && ($signed(prio_q) > $signed(new_prio_i));

  // next contents
  always_comb begin
    occ_d     = occ_q;
    payload_d = payload_q;
    prio_d    = prio_q;
    if (cmd_i.push && !gt_o) begin
      if (left_gt_i) begin
        occ_d     = 1'b1;
        payload_d = new_payload_i;
        prio_d    = new_prio_i;
      end else begin
        occ_d     = left_occ_i;
        payload_d = left_payload_i;
        prio_d    = left_prio_i;
      end
    end else if (cmd_i.pop) begin
      occ_d     = right_occ_i;
      payload_d = right_payload_i;
      prio_d    = right_prio_i;
    end
  end

  // occupied flag is control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // entry data, no reset
  always_ff @(posedge clk_i) begin
    payload_q <= payload_d;
    prio_q    <= prio_d;
  end

  assign occ_o     = occ_q;
  assign payload_o = payload_q;
  assign prio_o    = prio_q;

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue in a sorted chain of cells
// Top level: request handshake, entry counter, cell chain and response register.
// ----------------------------------------------------------------------------
// The queue keeps up to CAPACITY entries in a row of cells sorted by descending
// signed priority, the head in cell 0. A push lands behind every entry of
// strictly higher priority and ahead of equal ones, so ties leave last-in
// first-out; a pop returns the head. Every request gives exactly one response
// with status, occupancy and an empty flag. All cells compare against the new
// priority in parallel and shift by one place in the same edge, and the
// response sits in an output register, so a new request is taken every cycle
// unless a waiting response is not being taken. A push on a full queue is
// dropped with status full; a pop on an empty queue returns 0 with status
// empty. Stored payloads keep the low PAYLOAD_WIDTH bits (at most 32) and
// priorities the low PRIORITY_WIDTH bits of the request field.
module sorted_priority_queue #(
  parameter int unsigned CAPACITY       = 16,
  parameter int unsigned PAYLOAD_WIDTH  = 32,
  parameter int unsigned PRIORITY_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  spq_pkg::spq_req_t req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output spq_pkg::spq_rsp_t rsp_o
);

  localparam int unsigned VW  = spq_pkg::ValueWidth;
  localparam int unsigned PFW = spq_pkg::PrioWidth;
  localparam int unsigned OW  = spq_pkg::OccWidth;
  localparam int unsigned PLW = (PAYLOAD_WIDTH < VW) ? PAYLOAD_WIDTH : VW;
  localparam int unsigned PRW = PRIORITY_WIDTH;
  localparam int unsigned CW  = $clog2(CAPACITY + 1);

  logic                fire;
  spq_pkg::spq_cmd_t   cmd;
  logic [CW-1:0]       count_q, count_d;
  logic                full, empty;
  logic [PLW-1:0]      new_payload;
  logic [PRW-1:0]      new_prio;
  logic [PRW+PFW-1:0]  prio_ext;
  logic [VW+PLW-1:0]   head_ext;
  logic [CW+OW-1:0]    occ_ext;
  logic                rsp_valid_q;
  spq_pkg::spq_rsp_t   rsp_q, rsp_d;

  logic                cell_gt  [CAPACITY];
  logic                cell_occ [CAPACITY];
  logic [PLW-1:0]      cell_pl  [CAPACITY];
  logic [PRW-1:0]      cell_pr  [CAPACITY];

  // handshake: a waiting response only blocks while it is not taken
  assign req_ready_o = !rsp_valid_q || rsp_ready_i;
  assign fire        = req_valid_i && req_ready_o;

  assign full  = (count_q == CW'(CAPACITY));
  assign empty = (count_q == '0);

  assign cmd.push = fire && (req_i.kind == spq_pkg::KIND_PUSH) && !full;
  assign cmd.pop  = fire && (req_i.kind == spq_pkg::KIND_POP) && !empty;

  // incoming entry, cut to the stored widths
  assign new_payload = req_i.item_value[PLW-1:0];
  assign prio_ext    = (PRW + PFW)'(req_i.priority_req);
  assign new_prio    = prio_ext[PRW-1:0];

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic           l_gt, l_occ, r_occ;
    logic [PLW-1:0] l_pl, r_pl;
    logic [PRW-1:0] l_pr, r_pr;

    if (i == 0) begin : g_head
      assign l_gt  = 1'b1;
      assign l_occ = 1'b0;
      assign l_pl  = new_payload;
      assign l_pr  = new_prio;
    end else begin : g_mid
      assign l_gt  = cell_gt[i-1];
      assign l_occ = cell_occ[i-1];
      assign l_pl  = cell_pl[i-1];
      assign l_pr  = cell_pr[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_occ = 1'b0;
      assign r_pl  = '0;
      assign r_pr  = '0;
    end else begin : g_body
      assign r_occ = cell_occ[i+1];
      assign r_pl  = cell_pl[i+1];
      assign r_pr  = cell_pr[i+1];
    end

    spq_cell #(
      .PLW (PLW),
      .PRW (PRW)
    ) u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .cmd_i           (cmd),
      .new_payload_i   (new_payload),
      .new_prio_i      (new_prio),
      .left_gt_i       (l_gt),
      .left_occ_i      (l_occ),
      .left_payload_i  (l_pl),
      .left_prio_i     (l_pr),
      .right_occ_i     (r_occ),
      .right_payload_i (r_pl),
      .right_prio_i    (r_pr),
      .gt_o            (cell_gt[i]),
      .occ_o           (cell_occ[i]),
      .payload_o       (cell_pl[i]),
      .prio_o          (cell_pr[i])
    );
  end

  // entry counter
  always_comb begin
    count_d = count_q;
    if (cmd.push) begin
      count_d = count_q + CW'(1);
    end else if (cmd.pop) begin
      count_d = count_q - CW'(1);
    end
  end

  // response for the current request
  assign head_ext = (VW + PLW)'(cell_pl[0]);
  assign occ_ext  = (CW + OW)'(count_d);

  always_comb begin
    rsp_d.popped_value = cmd.pop ? head_ext[VW-1:0] : '0;
    rsp_d.status       = spq_pkg::ST_DONE;
    if (req_i.kind == spq_pkg::KIND_PUSH) begin
      if (full) begin
        rsp_d.status = spq_pkg::ST_FULL;
      end
    end else if (empty) begin
      rsp_d.status = spq_pkg::ST_EMPTY;
    end
    rsp_d.now_empty = (count_d == '0);
    rsp_d.occupancy = occ_ext[OW-1:0];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // response payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef SYNTH
  // counter never passes the capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // head cell occupied exactly when the queue is not empty
  a_head_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_occ[0] == (count_q != '0))
    else $error("head cell occupancy disagrees with count");

  // tail cell occupied exactly when the queue is full
  a_tail_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_occ[CAPACITY-1] == (count_q == CW'(CAPACITY)))
    else $error("tail cell occupancy disagrees with count");

  // a successful pop removes exactly one entry
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |=> count_q == $past(count_q) - CW'(1))
    else $error("pop did not remove one entry");

  // a waiting response agrees with the current count
  a_rsp_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (rsp_q.now_empty == (count_q == '0)))
    else $error("empty flag disagrees with count");
`endif

endmodule
